>>> design/phbac_pkg.sv
// Shared types, register codes and helpers for the pH block averager.
package phbac_pkg;

	localparam int DivNumW = 56;
	localparam int DivDenW = 40;
	localparam int DivCntW = 6;

	// Register indexes on the configuration port
	typedef enum logic [2:0] {
		REG_WINDOW_COUNT  = 3'd0,
		REG_CAL_VOLT_LOW  = 3'd1,
		REG_CAL_PH_LOW    = 3'd2,
		REG_CAL_VOLT_MID  = 3'd3,
		REG_CAL_PH_MID    = 3'd4,
		REG_CAL_VOLT_HIGH = 3'd5,
		REG_CAL_PH_HIGH   = 3'd6
	} reg_index_t;

	typedef struct packed {
		logic               start;
		logic [DivNumW-1:0] dividend;
		logic [DivDenW-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic               busy;
		logic               done;
		logic [DivNumW-1:0] quotient;
	} div_rsp_t;

	// Apply the sign to a quotient magnitude and clamp to 16-bit signed
	function automatic logic signed [15:0] sat16(input logic [DivNumW-1:0] mag,
		input logic neg);
		logic signed [15:0] r;
		if (neg) begin
			if (mag > DivNumW'(32768)) r = 16'sh8000;
			else r = 16'(-mag);
		end else begin
			if (mag > DivNumW'(32767)) r = 16'sh7fff;
			else r = mag[15:0];
		end
		return r;
	endfunction

endpackage

>>> design/ph_block_average_calibrate.sv
// Top level: sample accumulator, calibration sequencer, shared multiplier and divider.
//
// Each sample is taken while the block is idle. The sample that closes a window
// starts a result computation: one pass of the bit-serial divider for the
// mean, then the shared 32x32 multiplier for the line and quadratic terms, and
// two more divider passes for the rounded pH values; with coinciding
// calibration voltages only the mean is divided. The result sits in an output
// register, so samples are taken again while it waits to be read. There is no
// clearing pass after reset.
module ph_block_average_calibrate (
	input  logic        clk,
	input  logic        arst_n,
	// fields from bit 0: sample_mv[11:0]
	input  logic [15:0] s_tdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	// fields from bit 0: average_mv[11:0], ph_linear[27:12], ph_quadratic[43:28]
	output logic [47:0] m_tdata,
	// fields from bit 0: calib_error
	output logic        m_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_AVG  = 6'b000010,
		ST_MUL  = 6'b000100,
		ST_DIVL = 6'b001000,
		ST_DIVQ = 6'b010000,
		ST_OUT  = 6'b100000
	} state_t;

	typedef enum logic [3:0] {
		MS_QA1 = 4'd0, MS_QB1 = 4'd1, MS_QC1 = 4'd2,
		MS_QA2 = 4'd3, MS_QB2 = 4'd4, MS_QC2 = 4'd5,
		MS_QA3 = 4'd6, MS_QB3 = 4'd7, MS_QC3 = 4'd8,
		MS_DA  = 4'd9, MS_DB  = 4'd10,
		MS_LA  = 4'd11, MS_LB = 4'd12, MS_LGO = 4'd13
	} step_t;

	state_t state_q;
	step_t  step_q;

	logic [15:0] window_q;
	logic [11:0] v1_q, v2_q, v3_q;
	logic [13:0] p1_q, p2_q, p3_q;
	logic [27:0] sum_q;
	logic [15:0] cnt_q;
	logic [11:0] avg_q;
	logic signed [31:0] ta_q, tb_q;
	logic signed [55:0] acc_q;
	logic signed [39:0] den_q;
	logic signed [15:0] lin_q;
	logic signed [15:0] quad_q;
	logic        neg_q;
	logic [47:0] out_data_q;
	logic        out_err_q;
	logic        out_valid_q;

	logic        s_acc;
	logic [27:0] sum_n;
	logic [15:0] cnt_n;
	logic        close;
	logic        err;
	logic signed [12:0] dv1, dv2, dv3, d12, d13, d23;
	logic signed [15:0] dp31;
	logic signed [31:0] opa, opb;
	logic signed [63:0] prod;
	logic signed [55:0] dnum;
	logic signed [39:0] dden;
	logic [55:0] dnum_mag;
	logic [39:0] dden_mag;
	logic        out_load;
	logic signed [15:0] quot_sat;

	phbac_pkg::div_req_t div_req;
	phbac_pkg::div_rsp_t div_rsp;

	phbac_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= 16'd1500;
			v1_q     <= 12'd1770;
			p1_q     <= 14'd4000;
			v2_q     <= 12'd1639;
			p2_q     <= 14'd6860;
			v3_q     <= 12'd1496;
			p3_q     <= 14'd9180;
		end else if (cfg_we) begin
			case (cfg_index)
				phbac_pkg::REG_WINDOW_COUNT:  window_q <= cfg_data;
				phbac_pkg::REG_CAL_VOLT_LOW:  v1_q <= cfg_data[11:0];
				phbac_pkg::REG_CAL_PH_LOW:    p1_q <= cfg_data[13:0];
				phbac_pkg::REG_CAL_VOLT_MID:  v2_q <= cfg_data[11:0];
				phbac_pkg::REG_CAL_PH_MID:    p2_q <= cfg_data[13:0];
				phbac_pkg::REG_CAL_VOLT_HIGH: v3_q <= cfg_data[11:0];
				phbac_pkg::REG_CAL_PH_HIGH:   p3_q <= cfg_data[13:0];
				default: ;
			endcase
		end
	end

	// Window accumulation
	assign s_tready = state_q == ST_IDLE;
	assign s_acc    = s_tvalid && s_tready;
	assign sum_n    = sum_q + 28'(s_tdata[11:0]);
	assign cnt_n    = cnt_q + 16'd1;
	assign close    = !(cnt_n < window_q || cnt_n == 16'd0);

	// Calibration differences
	assign err  = (v1_q == v2_q) || (v1_q == v3_q) || (v2_q == v3_q);
	assign dv1  = $signed({1'b0, avg_q}) - $signed({1'b0, v1_q});
	assign dv2  = $signed({1'b0, avg_q}) - $signed({1'b0, v2_q});
	assign dv3  = $signed({1'b0, avg_q}) - $signed({1'b0, v3_q});
	assign d12  = $signed({1'b0, v1_q}) - $signed({1'b0, v2_q});
	assign d13  = $signed({1'b0, v1_q}) - $signed({1'b0, v3_q});
	assign d23  = $signed({1'b0, v2_q}) - $signed({1'b0, v3_q});
	assign dp31 = $signed({2'b0, p3_q}) - $signed({2'b0, p1_q});

	// Operand select for the shared multiplier
	always_comb begin
		opa = '0;
		opb = '0;
		case (step_q)
			MS_QA1: begin opa = 32'(signed'({2'b0, p1_q})); opb = 32'(d23); end
			MS_QB1: begin opa = 32'(dv2); opb = 32'(dv3); end
			MS_QA2: begin opa = 32'(signed'({2'b0, p2_q})); opb = 32'(d13); end
			MS_QB2: begin opa = 32'(dv1); opb = 32'(dv3); end
			MS_QA3: begin opa = 32'(signed'({2'b0, p3_q})); opb = 32'(d12); end
			MS_QB3: begin opa = 32'(dv1); opb = 32'(dv2); end
			MS_QC1, MS_QC2, MS_QC3: begin opa = ta_q; opb = tb_q; end
			MS_DA:  begin opa = 32'(d12); opb = 32'(d13); end
			MS_DB:  begin opa = ta_q; opb = 32'(d23); end
			MS_LA:  begin opa = 32'(signed'({2'b0, p1_q})); opb = -32'(d13); end
			MS_LB:  begin opa = 32'(dp31); opb = 32'(dv1); end
			default: ;
		endcase
	end
	assign prod = opa * opb;

	// Divider operands: mean, then rounded line and quadratic quotients
	always_comb begin
		dnum = '0;
		dden = '0;
		if (state_q == ST_MUL) begin
			dnum = 56'(ta_q + tb_q);
			dden = 40'(-d13);
		end else begin
			dnum = acc_q;
			dden = den_q;
		end
	end
	assign dnum_mag = dnum[55] ? 56'(-dnum) : 56'(dnum);
	assign dden_mag = dden[39] ? 40'(-dden) : 40'(dden);

	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = {dnum_mag[54:0], 1'b0} + 56'(dden_mag);
		div_req.divisor  = {dden_mag[38:0], 1'b0};
		case (state_q)
			ST_IDLE: begin
				div_req.start    = s_acc && close;
				div_req.dividend = 56'(sum_n);
				div_req.divisor  = 40'(cnt_n);
			end
			ST_MUL:  div_req.start = step_q == MS_LGO;
			ST_DIVL: div_req.start = div_rsp.done;
			default: ;
		endcase
	end

	assign quot_sat = phbac_pkg::sat16(div_rsp.quotient, neg_q);
	assign out_load = state_q == ST_OUT && (!out_valid_q || m_tready);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= MS_QA1;
			sum_q   <= '0;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						sum_q <= close ? '0 : sum_n;
						cnt_q <= close ? '0 : cnt_n;
						if (close) state_q <= ST_AVG;
					end
				end
				ST_AVG: begin
					if (div_rsp.done) begin
						step_q  <= MS_QA1;
						state_q <= err ? ST_OUT : ST_MUL;
					end
				end
				ST_MUL: begin
					if (step_q == MS_LGO) state_q <= ST_DIVL;
					else step_q <= step_t'(step_q + 4'd1);
				end
				ST_DIVL: if (div_rsp.done) state_q <= ST_DIVQ;
				ST_DIVQ: if (div_rsp.done) state_q <= ST_OUT;
				ST_OUT:  if (out_load) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Arithmetic registers
	always_ff @(posedge clk) begin
		if (state_q == ST_AVG && div_rsp.done) begin
			avg_q  <= div_rsp.quotient[11:0];
			lin_q  <= '0;
			quad_q <= '0;
			acc_q  <= '0;
		end
		if (state_q == ST_MUL) begin
			case (step_q)
				MS_QA1, MS_QA2, MS_QA3, MS_DA, MS_LA: ta_q <= prod[31:0];
				MS_QB1, MS_QB2, MS_QB3, MS_LB:        tb_q <= prod[31:0];
				MS_QC1, MS_QC3: acc_q <= acc_q + prod[55:0];
				MS_QC2:         acc_q <= acc_q - prod[55:0];
				MS_DB:          den_q <= prod[39:0];
				default: ;
			endcase
		end
		if (div_req.start) neg_q <= dnum[55] ^ dden[39];
		if (state_q == ST_DIVL && div_rsp.done) lin_q <= quot_sat;
		if (state_q == ST_DIVQ && div_rsp.done) quad_q <= quot_sat;
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Load the whole result at once so a waiting transaction is never disturbed
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q[11:0]  <= avg_q;
			out_data_q[27:12] <= lin_q;
			out_data_q[43:28] <= quad_q;
			out_data_q[47:44] <= '0;
			out_err_q         <= err;
		end
	end

	assign m_tdata  = out_data_q;
	assign m_tuser  = out_err_q;
	assign m_tvalid = out_valid_q;

	// Checks
	a_err_zero_ph: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[43:12] == 32'd0)
		else $error("calibration error result carries nonzero pH");
	a_div_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider started while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_OUT && out_valid_q && !m_tready |=> state_q == ST_OUT)
		else $error("result dropped while output stalled");
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !div_rsp.busy)
		else $error("input taken during computation");

endmodule

>>> design/phbac_divider.sv
// Bit-serial restoring unsigned divider, one quotient bit per cycle.
module phbac_divider (
	input  logic                clk,
	input  logic                arst_n,
	input  phbac_pkg::div_req_t req,
	output phbac_pkg::div_rsp_t rsp
);

	logic [phbac_pkg::DivDenW:0]   rem_q;
	logic [phbac_pkg::DivNumW-1:0] quo_q;
	logic [phbac_pkg::DivDenW-1:0] den_q;
	logic [phbac_pkg::DivCntW-1:0] cnt_q;
	logic                          busy_q;
	logic                          done_q;
	logic [phbac_pkg::DivDenW:0]   rem_sh;
	logic                          fits;

	// Shift in the next dividend bit and trial-subtract
	assign rem_sh = {rem_q[phbac_pkg::DivDenW-1:0], quo_q[phbac_pkg::DivNumW-1]};
	assign fits   = rem_sh >= {1'b0, den_q};

	// Control: count iterations, pulse done after the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == phbac_pkg::DivCntW'(phbac_pkg::DivNumW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			den_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? rem_sh - {1'b0, den_q} : rem_sh;
			quo_q <= {quo_q[phbac_pkg::DivNumW-2:0], fits};
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule
